### rtl/crhs_pkg.sv
// ----------------------------------------------------------------------------
// crhs_pkg
// Shared types and constants for the channel RSSI histogram smoother.
// ----------------------------------------------------------------------------
package crhs_pkg;

    localparam int NumChannels = 13;
    localparam int IdxW        = (NumChannels > 1) ? $clog2(NumChannels) : 1;

    localparam int ChanW    = 4;
    localparam int RssiW    = 8;
    localparam int LevelW   = 6;
    localparam int ColorW   = 16;
    localparam int KindW    = 2;
    localparam int CfgAddrW = 1;
    localparam int CfgDataW = 6;

    // Input item kinds
    localparam logic [KindW-1:0] KindReport = 2'd0;
    localparam logic [KindW-1:0] KindCommit = 2'd1;
    localparam logic [KindW-1:0] KindLive   = 2'd2;

    // Configuration register indexes
    localparam logic [CfgAddrW-1:0] CfgEnable    = 1'd0;
    localparam logic [CfgAddrW-1:0] CfgMaxHeight = 1'd1;

    // Entry update operations
    typedef logic [1:0] t_op;
    localparam t_op OpReport = 2'd0;
    localparam t_op OpCommit = 2'd1;
    localparam t_op OpLive   = 2'd2;

    localparam logic signed [RssiW-1:0] PeakReset      = -8'sd127;
    localparam logic [LevelW-1:0]       MaxHeightReset = 6'd50;

    typedef logic [IdxW-1:0] t_idx;

    typedef struct packed {
        logic signed [RssiW-1:0] peak;
        logic [LevelW-1:0]       level;
    } t_entry;

    localparam t_entry EntryReset = '{peak: PeakReset, level: '0};

    // Request from the sequencer to the channel memory
    typedef struct packed {
        logic   clr;
        logic   rd_en;
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_entry wr_data;
    } t_mem_req;

endpackage

### rtl/crhs_mem.sv
// ----------------------------------------------------------------------------
// crhs_mem
// Per-channel entry memory: one write and one registered read per cycle,
// with valid bits so that unwritten entries read as their reset value.
// ----------------------------------------------------------------------------
module crhs_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crhs_pkg::t_mem_req i_req,
    output crhs_pkg::t_entry   o_rd_data
);
    import crhs_pkg::*;

    t_entry                 r_mem [NumChannels];
    logic [NumChannels-1:0] r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_hit  <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : EntryReset;

endmodule

### rtl/crhs_upd.sv
// ----------------------------------------------------------------------------
// crhs_upd
// Entry update: peak hold for reports, bar mapping and (2*old+bar)/3 blend
// for commits and live samples.
// ----------------------------------------------------------------------------
module crhs_upd (
    input  crhs_pkg::t_op                          i_op,
    input  logic signed [crhs_pkg::RssiW-1:0]      i_rssi,
    input  crhs_pkg::t_entry                       i_rd,
    output crhs_pkg::t_entry                       o_wr,
    output logic                                   o_wr_need
);
    import crhs_pkg::*;

    // Map dBm to a 0..63 bar: (r+100)*63/70 = 9x/10, /10 as *205>>11
    function automatic logic [LevelW-1:0] f_to_bar(input logic signed [RssiW-1:0] r);
        logic signed [8:0] s;
        logic [9:0]        n;
        logic [17:0]       p;
        s = 9'(r) + 9'sd100;
        n = 10'(s[6:0]) * 10'd9;
        p = 18'(n) * 18'd205;
        if (r >= -8'sd30) return 6'd63;
        if (r <= -8'sd100) return 6'd0;
        return p[16:11];
    endfunction

    // (2*old+bar)/3, /3 as *171>>9
    function automatic logic [LevelW-1:0] f_blend(input logic [LevelW-1:0] old_lvl,
                                                  input logic [LevelW-1:0] bar);
        logic [8:0]  n;
        logic [15:0] p;
        n = {2'b00, old_lvl, 1'b0} + 9'(bar);
        p = 16'(n) * 16'd171;
        return p[14:9];
    endfunction

    logic signed [RssiW-1:0] w_src;
    logic [LevelW-1:0]       w_bar;
    logic [LevelW-1:0]       w_lvl;

    assign w_src = (i_op == OpLive) ? i_rssi : i_rd.peak;
    assign w_bar = f_to_bar(w_src);
    assign w_lvl = f_blend(i_rd.level, w_bar);

    always_comb begin
        case (i_op)
            OpReport: begin
                o_wr      = '{peak: i_rssi, level: i_rd.level};
                o_wr_need = (i_rssi > i_rd.peak);
            end
            OpCommit: begin
                o_wr      = '{peak: PeakReset, level: w_lvl};
                o_wr_need = 1'b1;
            end
            OpLive: begin
                o_wr      = '{peak: i_rd.peak, level: w_lvl};
                o_wr_need = 1'b1;
            end
            default: begin
                o_wr      = i_rd;
                o_wr_need = 1'b0;
            end
        endcase
    end

endmodule

### rtl/crhs_disp.sv
// ----------------------------------------------------------------------------
// crhs_disp
// Display stage: clamp the level to the height limit and build the RGB565
// color ramp for that height.
// ----------------------------------------------------------------------------
module crhs_disp (
    input  logic [crhs_pkg::LevelW-1:0] i_level,
    input  logic [crhs_pkg::LevelW-1:0] i_max_height,
    output logic [crhs_pkg::LevelW-1:0] o_height,
    output logic [crhs_pkg::ColorW-1:0] o_color
);
    import crhs_pkg::*;

    // Blue-to-magenta-to-red ramp; 255*d/24 as 85*d>>3, 255*d/22 as *2979>>16
    function automatic logic [ColorW-1:0] f_ramp(input logic [LevelW-1:0] h);
        logic [4:0]  d;
        logic [10:0] p85;
        logic [7:0]  t;
        logic [12:0] m;
        logic [23:0] p22;
        logic [7:0]  u;
        d   = 5'(h - 6'd16);
        p85 = 11'(d) * 11'd85;
        t   = p85[10:3];
        if (h <= 6'd15) return {11'b0, h[1:0], 3'b000};
        if (h <= 6'd40) return {5'h1F, 3'b000, t[7:5], t[5:1]};
        d   = 5'(h - 6'd41);
        m   = 13'(d) * 13'd255;
        p22 = 24'(m) * 24'd2979;
        u   = ~p22[23:16];
        return {5'h1F, 5'b00000, u[7], u[4:0]};
    endfunction

    assign o_height = (i_level > i_max_height) ? i_max_height : i_level;
    assign o_color  = f_ramp(o_height);

endmodule

### rtl/channel_rssi_histogram_smoother.sv
// ----------------------------------------------------------------------------
// channel_rssi_histogram_smoother
// Per-channel RSSI peak hold with smoothed bar levels and display colors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries kind, channel, rssi.
//   A scan report updates the held peak of its channel; an end-of-scan commit
//   walks all channels, blends each peak into its level and emits one result
//   per channel (o_last on the final one); a live sample blends one channel
//   and emits one result. Bad channels, kind three and commits with no report
//   since the last commit give no result.
//   Output channel (o_out_valid / i_out_stall) carries one result per transfer.
//   One item is handled at a time. A report reads the memory, then writes
//   back. A live sample reads its entry, then writes it back as it loads the
//   output register; a commit does so for each channel in turn. Both pause
//   while a result in the output register stays stalled.
//   A stalled result holds in the output register; the walk pauses until it
//   moves, and a new item is still taken once the walk has finished.
//   Reset: enable 1, max_height 50, all peaks -127, all levels zero.
//   Writing enable 0 clears peaks, levels and the report flag at once;
//   while disabled every item is taken and dropped.
// ----------------------------------------------------------------------------
module channel_rssi_histogram_smoother (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [crhs_pkg::CfgAddrW-1:0]         i_cfg_addr,
    input  logic [crhs_pkg::CfgDataW-1:0]         i_cfg_data,
    // input items
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [crhs_pkg::KindW-1:0]            i_kind,
    input  logic [crhs_pkg::ChanW-1:0]            i_channel,
    input  logic signed [crhs_pkg::RssiW-1:0]     i_rssi,
    // results
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [crhs_pkg::ChanW-1:0]            o_out_channel,
    output logic [crhs_pkg::LevelW-1:0]           o_level,
    output logic [crhs_pkg::LevelW-1:0]           o_height,
    output logic [crhs_pkg::ColorW-1:0]           o_color,
    output logic                                  o_last
);
    import crhs_pkg::*;

    localparam logic [1:0] StIdle   = 2'd0;
    localparam logic [1:0] StReport = 2'd1;
    localparam logic [1:0] StCalc   = 2'd2;

    // Sequencer state
    logic [1:0]              r_state, n_state;
    t_idx                    r_idx, n_idx;
    t_op                     r_op, n_op;
    logic signed [RssiW-1:0] r_rssi, n_rssi;
    logic                    r_any, n_any;
    logic                    r_enable, n_enable;
    logic [LevelW-1:0]       r_max_height, n_max_height;

    // Output register
    logic                    r_out_valid, n_out_valid;
    logic [ChanW-1:0]        r_out_chan;
    logic [LevelW-1:0]       r_out_level;
    logic                    r_out_last;

    t_mem_req                w_req;
    t_entry                  w_rd;
    t_entry                  w_wr;
    logic                    w_wr_need;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_ch_ok;
    t_idx                    w_ch_idx;
    logic                    w_load;
    logic                    w_load_last;

    assign o_in_stall = (r_state != StIdle);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ch_ok    = (i_channel >= ChanW'(1)) && (i_channel <= ChanW'(NumChannels));
    assign w_ch_idx   = IdxW'(i_channel - ChanW'(1));

    crhs_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd)
    );

    crhs_upd u_upd (
        .i_op      (r_op),
        .i_rssi    (r_rssi),
        .i_rd      (w_rd),
        .o_wr      (w_wr),
        .o_wr_need (w_wr_need)
    );

    crhs_disp u_disp (
        .i_level      (r_out_level),
        .i_max_height (r_max_height),
        .o_height     (o_height),
        .o_color      (o_color)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_op         = r_op;
        n_rssi       = r_rssi;
        n_any        = r_any;
        n_enable     = r_enable;
        n_max_height = r_max_height;
        w_load       = 1'b0;
        w_load_last  = 1'b0;

        w_req         = '0;
        w_req.rd_addr = r_idx;
        w_req.wr_addr = r_idx;
        w_req.wr_data = w_wr;

        unique case (r_state)
            StIdle: begin
                if (w_in_acc && r_enable) begin
                    unique case (i_kind)
                        KindReport: begin
                            // A report on any channel arms the next commit
                            n_any = 1'b1;
                            if (w_ch_ok) begin
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = w_ch_idx;
                                n_idx         = w_ch_idx;
                                n_rssi        = i_rssi;
                                n_op          = OpReport;
                                n_state       = StReport;
                            end
                        end
                        KindCommit: begin
                            if (r_any) begin
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = '0;
                                n_idx         = '0;
                                n_op          = OpCommit;
                                n_any         = 1'b0;
                                n_state       = StCalc;
                            end
                        end
                        KindLive: begin
                            if (w_ch_ok) begin
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = w_ch_idx;
                                n_idx         = w_ch_idx;
                                n_rssi        = i_rssi;
                                n_op          = OpLive;
                                n_state       = StCalc;
                            end
                        end
                        default: begin
                            // drop unused kind
                        end
                    endcase
                end
            end
            StReport: begin
                // Write back only when the new report beats the held peak
                w_req.wr_en = w_wr_need;
                n_state     = StIdle;
            end
            StCalc: begin
                // Hold read data until the output register can take a result
                if (w_out_free) begin
                    w_req.wr_en = 1'b1;
                    w_load      = 1'b1;
                    w_load_last = (r_op == OpLive) || (r_idx == t_idx'(NumChannels - 1));
                    if (w_load_last) begin
                        n_state = StIdle;
                    end else begin
                        n_idx         = t_idx'(r_idx + 1'b1);
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = t_idx'(r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CfgEnable: begin
                    n_enable = i_cfg_data[0];
                    if (!i_cfg_data[0]) begin
                        w_req.clr = 1'b1;
                        n_any     = 1'b0;
                    end
                end
                CfgMaxHeight: begin
                    n_max_height = i_cfg_data[LevelW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign n_out_valid = w_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= StIdle;
            r_any        <= 1'b0;
            r_enable     <= 1'b1;
            r_max_height <= MaxHeightReset;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_any        <= n_any;
            r_enable     <= n_enable;
            r_max_height <= n_max_height;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_op   <= n_op;
        r_rssi <= n_rssi;
        if (w_load) begin
            r_out_chan  <= ChanW'(r_idx) + ChanW'(1);
            r_out_level <= w_wr.level;
            r_out_last  <= w_load_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_chan;
    assign o_level       = r_out_level;
    assign o_last        = r_out_last;

endmodule

### rtl/crhs_chk.sv
// ----------------------------------------------------------------------------
// crhs_chk
// Port-level checks for the channel RSSI histogram smoother.
// ----------------------------------------------------------------------------
module crhs_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [crhs_pkg::ChanW-1:0]        o_out_channel,
    input  logic [crhs_pkg::LevelW-1:0]       o_level,
    input  logic [crhs_pkg::LevelW-1:0]       o_height,
    input  logic [crhs_pkg::ColorW-1:0]       o_color,
    input  logic                              o_last
);
    import crhs_pkg::*;

    // A stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_channel) && $stable(o_level)
             && $stable(o_height) && $stable(o_color) && $stable(o_last)))
        else $error("stalled result changed");

    // Reported channel is always a real channel
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_channel >= ChanW'(1))
                        && (o_out_channel <= ChanW'(NumChannels)))
        else $error("result channel out of range");

    // Display height never exceeds the level it is clamped from
    a_height_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_height <= o_level))
        else $error("height above level");

    // While a commit walk is mid-run, no new item is taken
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_in_stall)
        else $error("input taken during commit walk");

endmodule

bind channel_rssi_histogram_smoother crhs_chk u_crhs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_channel (o_out_channel),
    .o_level       (o_level),
    .o_height      (o_height),
    .o_color       (o_color),
    .o_last        (o_last)
);

### dv/crhs_level_checker.sv
// ----------------------------------------------------------------------------
// crhs_level_checker
// Passive checker for the channel RSSI histogram smoother: it follows the
// register writes and input transfers, predicts every bar result and compares
// each output transfer field by field with the oldest predicted bar.
// ----------------------------------------------------------------------------
module crhs_level_checker
    import crhs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CfgAddrW-1:0]     i_cfg_addr,
    input  logic [CfgDataW-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [KindW-1:0]        i_kind,
    input  logic [ChanW-1:0]        i_channel,
    input  logic signed [RssiW-1:0] i_rssi,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [ChanW-1:0]        i_out_channel,
    input  logic [LevelW-1:0]       i_level,
    input  logic [LevelW-1:0]       i_height,
    input  logic [ColorW-1:0]       i_color,
    input  logic                    i_last,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ChanW-1:0]  chan;
        logic [LevelW-1:0] level;
        logic [LevelW-1:0] height;
        logic [ColorW-1:0] color;
        logic              last;
    } t_bar;

    logic                    enabled;
    logic [LevelW-1:0]       height_cap;
    logic signed [RssiW-1:0] peak_of [NumChannels];
    logic [LevelW-1:0]       level_of [NumChannels];
    logic                    scan_seen;
    t_bar                    bars_due [$];
    int                      fail_count = 0;
    int                      pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic logic [LevelW-1:0] rssi_to_bar(logic signed [RssiW-1:0] rssi);
        int r;
        r = rssi;
        if (r >= -30) return 6'd63;
        if (r <= -100) return 6'd0;
        return LevelW'((r + 100) * 63 / 70);
    endfunction

    function automatic logic [LevelW-1:0] blend_level(logic [LevelW-1:0] old_lv,
                                                      logic [LevelW-1:0] bar);
        int v;
        v = (2 * int'(old_lv) + int'(bar)) / 3;
        return LevelW'(v & 63);
    endfunction

    // RGB565 ramp: blue below 16, red to magenta up to 40, then fading back
    function automatic logic [ColorW-1:0] height_color(logic [LevelW-1:0] h);
        int hv;
        int t;
        hv = h;
        if (hv <= 15) return ColorW'((hv << 3) & 'h1F);
        if (hv <= 40) begin
            t = ((hv - 16) * 255 / 24) & 'hFF;
            return ColorW'(((t >> 1) & 'h1F) | (t & 'h07E0) | 'hF800);
        end
        t = 255 - (((hv - 41) * 255 / 22) & 'hFF);
        return ColorW'((t & 'h1F) | ((t >> 2) & 'h07E0) | 'hF800);
    endfunction

    task automatic clear_levels();
        for (int i = 0; i < NumChannels; i++) begin
            peak_of[i]  = PeakReset;
            level_of[i] = '0;
        end
        scan_seen = 1'b0;
    endtask

    task automatic queue_bar(int idx, logic last);
        t_bar b;
        b.chan   = ChanW'(idx + 1);
        b.level  = level_of[idx];
        b.height = (level_of[idx] > height_cap) ? height_cap : level_of[idx];
        b.color  = height_color(b.height);
        b.last   = last;
        bars_due.push_back(b);
    endtask

    task automatic predict_item(logic [KindW-1:0] kind, logic [ChanW-1:0] ch,
                                logic signed [RssiW-1:0] rssi);
        logic on_band;
        int   idx;
        on_band = (ch >= 1) && (ch <= NumChannels);
        idx     = int'(ch) - 1;
        if (enabled) begin
            case (kind)
                KindReport: begin
                    scan_seen = 1'b1;
                    if (on_band && rssi > peak_of[idx]) peak_of[idx] = rssi;
                end
                KindCommit: if (scan_seen) begin
                    for (int i = 0; i < NumChannels; i++) begin
                        level_of[i] = blend_level(level_of[i], rssi_to_bar(peak_of[i]));
                        peak_of[i]  = PeakReset;
                        queue_bar(i, i == NumChannels - 1);
                    end
                    scan_seen = 1'b0;
                end
                KindLive: if (on_band) begin
                    level_of[idx] = blend_level(level_of[idx], rssi_to_bar(rssi));
                    queue_bar(idx, 1'b1);
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin : watch_edges
        t_bar want;
        if (!i_rst_n) begin
            enabled    = 1'b1;
            height_cap = MaxHeightReset;
            clear_levels();
            bars_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (bars_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result for channel %0d",
                                              i_out_channel));
                end else begin
                    want = bars_due.pop_front();
                    check_field("channel", i_out_channel, want.chan);
                    check_field("level", i_level, want.level);
                    check_field("height", i_height, want.height);
                    check_field("color", i_color, want.color);
                    check_field("last", i_last, want.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CfgEnable: begin
                        enabled = i_cfg_data[0];
                        if (!enabled) clear_levels();
                    end
                    CfgMaxHeight: height_cap = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_item(i_kind, i_channel, i_rssi);
        end
        pending = bars_due.size();
    end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top level for the channel RSSI histogram smoother: drives scan reports,
// commits and live samples through a sequence of register settings and idle
// patterns, while the level checker predicts and compares every bar result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crhs_pkg::*;

    // Kind three has no name in the package; the block ignores it
    localparam logic [KindW-1:0] KindSpare = 2'd3;

    localparam int CycleLimit   = 200000;
    localparam int SettleCycles = 6;
    localparam int QuietCycles  = 20;
    localparam int NumPhases    = 9;
    localparam int PhaseItems   = 34;
    localparam int PressurePhase = 4;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CfgAddrW-1:0]     i_cfg_addr = '0;
    logic [CfgDataW-1:0]     i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [KindW-1:0]        i_kind = '0;
    logic [ChanW-1:0]        i_channel = '0;
    logic signed [RssiW-1:0] i_rssi = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [ChanW-1:0]        o_out_channel;
    logic [LevelW-1:0]       o_level;
    logic [LevelW-1:0]       o_height;
    logic [ColorW-1:0]       o_color;
    logic                    o_last;

    int fail_count;
    int bars_pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Register setting per random phase; a cap of -1 means pick one at random
    logic phase_enable [NumPhases] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    int   phase_cap    [NumPhases] = '{63, 0, 20, 15, 16, 40, 41, -1, 50};

    channel_rssi_histogram_smoother dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_channel     (i_channel),
        .i_rssi        (i_rssi),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_channel (o_out_channel),
        .o_level       (o_level),
        .o_height      (o_height),
        .o_color       (o_color),
        .o_last        (o_last)
    );

    crhs_level_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_channel     (i_channel),
        .i_rssi        (i_rssi),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_channel (o_out_channel),
        .i_level       (o_level),
        .i_height      (o_height),
        .i_color       (o_color),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (bars_pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Stall the result channel at the current rate; zero gives a clean stretch
    always @(posedge i_clk) begin
        i_out_stall <= (int'($urandom_range(0, 99)) < recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle for a random number of cycles, then hold the item until it transfers.
    // Keep valid high across back-to-back items so it gets one assignment per edge.
    task automatic send_item(logic [KindW-1:0] kind, logic [ChanW-1:0] ch, int rssi);
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_channel  <= ch;
        i_rssi     <= RssiW'(rssi);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid, wait until every predicted bar has transferred, then let
    // any result-free work (a pending report write-back) finish.
    task automatic wait_drained(int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bars_pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write the display cap first, then enable; only called while idle
    task automatic configure(logic enable, int cap);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CfgMaxHeight;
        i_cfg_data <= CfgDataW'(cap);
        @(posedge i_clk);
        i_cfg_addr <= CfgEnable;
        i_cfg_data <= CfgDataW'(enable);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly the -105..-30 dBm band, some strong signals, some anything
    function automatic int pick_rssi();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return int'($urandom_range(0, 75)) - 105;
        if (r < 80) return int'($urandom_range(0, 25)) - 45;
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    function automatic logic [ChanW-1:0] pick_channel();
        if ($urandom_range(0, 9) == 0) return ChanW'($urandom_range(0, 15));
        return ChanW'($urandom_range(1, NumChannels));
    endfunction

    // Mostly whole scans (reports closed by a commit) with random content;
    // the rest is live samples, stray commits and ignored kinds.
    task automatic run_random(int budget);
        int done;
        int pick;
        int n;
        done = 0;
        while (done < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                n = $urandom_range(1, 12);
                repeat (n) send_item(KindReport, pick_channel(), pick_rssi());
                done += n;
                // leave a scan open now and then: its reports roll into the next one
                if ($urandom_range(0, 9) != 0) begin
                    send_item(KindCommit, ChanW'($urandom_range(0, 15)), pick_rssi());
                    done++;
                end
            end else if (pick < 85) begin
                send_item(KindLive, pick_channel(), pick_rssi());
                done++;
            end else if (pick < 92) begin
                send_item(KindCommit, ChanW'($urandom_range(0, 15)), pick_rssi());
                done++;
            end else begin
                send_item(KindSpare, ChanW'($urandom_range(0, 15)),
                          int'($urandom_range(0, 255)) - 128);
                done++;
            end
        end
    endtask

    initial begin
        int cap;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset settings
        send_idle_pct  = 25;
        recv_stall_pct = 51;
        send_item(KindCommit, 4'd1, -50);     // commit with no report: nothing
        send_item(KindLive, 4'd0, 0);         // live samples off the band: nothing
        send_item(KindLive, 4'd14, -50);
        send_item(KindLive, 4'd15, 127);
        send_item(KindSpare, 4'd5, -40);      // ignored kind
        send_item(KindReport, 4'd0, -20);     // off-band report still arms the commit
        send_item(KindCommit, 4'd0, 0);       // thirteen zero bars
        send_item(KindReport, 4'd1, 127);
        send_item(KindReport, 4'd13, -128);
        send_item(KindReport, 4'd7, -65);
        send_item(KindReport, 4'd7, -70);     // weaker, peak holds
        send_item(KindReport, 4'd2, -30);
        send_item(KindReport, 4'd3, -31);
        send_item(KindReport, 4'd4, -100);
        send_item(KindReport, 4'd5, -99);
        send_item(KindReport, 4'd15, 100);
        send_item(KindCommit, 4'd15, -1);
        send_item(KindCommit, 4'd3, 5);       // no report since the last commit: nothing
        send_item(KindLive, 4'd1, 127);
        send_item(KindLive, 4'd13, -128);
        send_item(KindLive, 4'd6, -30);
        send_item(KindLive, 4'd6, -100);
        send_item(KindSpare, 4'd0, -128);
        send_item(KindReport, 4'd8, -1);
        send_item(KindCommit, 4'd8, 0);

        // Random phases: sender idles less than receiver, then the reverse,
        // then both run flat out
        for (int p = 0; p < NumPhases; p++) begin
            if (p < 3) begin
                send_idle_pct  = 25;
                recv_stall_pct = 51;
            end else if (p < 6) begin
                send_idle_pct  = 51;
                recv_stall_pct = 25;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            wait_drained(SettleCycles);
            cap = (phase_cap[p] < 0) ? int'($urandom_range(0, 63)) : phase_cap[p];
            configure(phase_enable[p], cap);
            if (!phase_enable[p]) begin
                // dropped items; keep the phase short
                run_random(12);
            end else if (p == PressurePhase) begin
                run_random(PhaseItems / 2);
                wait_drained(0);
                run_random(PhaseItems / 2);
            end else begin
                run_random(PhaseItems);
            end
        end

        wait_drained(QuietCycles);
        if (fail_count == 0 && bars_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/crhs_pkg.sv
rtl/crhs_mem.sv
rtl/crhs_upd.sv
rtl/crhs_disp.sv
rtl/channel_rssi_histogram_smoother.sv
rtl/crhs_chk.sv
dv/crhs_level_checker.sv
dv/tb.sv
